// ----- hdl/md5_pkg.sv -----
// Package: MD5 constants, tables and shared types.
package md5_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [1:0] MODE_FULL   = 2'd0;
	localparam logic [1:0] MODE_MIDDLE = 2'd1;
	localparam logic [1:0] MODE_BASE62 = 2'd2;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] BASE62   = 7'd62;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} state_t;

	// Control from the sequencer to the round unit.
	typedef struct packed {
		logic       init;   // load working regs from chain
		logic       run;    // perform one round
		logic [5:0] idx;    // round index
		logic       fold;   // add working regs into chain
		logic       reset_chain;
	} rnd_ctrl_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [0:63];
		k = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
		};
		return k[i];
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	// Message word index used by round i.
	function automatic logic [3:0] round_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'((5 * i) + 1);
			2'd2: g = 4'((3 * i) + 5);
			default: g = 4'(7 * i);
		endcase
		return g;
	endfunction

endpackage

// ----- hdl/md5_round.sv -----
// Round unit: working registers, chaining words and one MD5 round per cycle when ctrl.run is set.
module md5_round (
	input  logic               clk,
	input  logic               arst_n,
	input  md5_pkg::rnd_ctrl_t ctrl,
	input  logic [31:0]        word,   // message word for the round in ctrl.idx
	output logic [127:0]       chain
);

	logic [31:0] ca_q, cb_q, cc_q, cd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f, t, rot;
	logic [4:0]  s;

	always_comb begin
		case (ctrl.idx[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		s   = md5_pkg::round_s(ctrl.idx);
		t   = a_q + f + word + md5_pkg::round_k(ctrl.idx);
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_q <= md5_pkg::INIT_A;
			cb_q <= md5_pkg::INIT_B;
			cc_q <= md5_pkg::INIT_C;
			cd_q <= md5_pkg::INIT_D;
		end else if (ctrl.reset_chain) begin
			ca_q <= md5_pkg::INIT_A;
			cb_q <= md5_pkg::INIT_B;
			cc_q <= md5_pkg::INIT_C;
			cd_q <= md5_pkg::INIT_D;
		end else if (ctrl.fold) begin
			ca_q <= ca_q + a_q;
			cb_q <= cb_q + b_q;
			cc_q <= cc_q + c_q;
			cd_q <= cd_q + d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			a_q <= ca_q;
			b_q <= cb_q;
			c_q <= cc_q;
			d_q <= cd_q;
		end else if (ctrl.run) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end

	assign chain = {cd_q, cc_q, cb_q, ca_q};

endmodule

// ----- hdl/md5_block_mem.sv -----
// Block memory: 16 message words, whole-word write, registered read.
module md5_block_mem (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [3:0]  wr_addr,
	input  logic [31:0] wr_data,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [0:15];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hdl/md5_message_digest.sv -----
// Top level: MD5 digest engine, byte input, byte/character result output.
// Usage:
//  - Write output_mode via cfg_we/cfg_data while idle: 0 full 16-byte
//    digest, 1 digest bytes 4..11, 2 eight base-62 characters (3 as 0).
//  - Transfer one item per start pulse when busy is low: msg_byte, is_last,
//    no_data. no_data with is_last low is an idle item.
//  - Each byte is merged into a 16-word block memory (the word being
//    assembled is kept in a holding register). When the 64th byte lands,
//    the block runs 64 rounds, one per cycle from the block memory
//    (registered read), then a fold step adds the working registers
//    into the chaining words.
//  - On is_last the padding bytes are inserted one per cycle (0x80, zeros,
//    then the bit length little-endian), pausing to compress as blocks fill.
//  - Results then appear on out_byte with out_valid high for one cycle
//    each, 16 or 8 results back to back, out_last on the final one. The
//    receiver cannot stall; busy stays high until the last result.
//  - After the results the chaining words, bit count and fill return to
//    their reset values. Asynchronous reset (arst_n) does the same and
//    resets output_mode to 0.
module md5_message_digest (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] msg_byte,
	input  logic       is_last,
	input  logic       no_data,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_last
);

	md5_pkg::state_t state_q, state_d;
	md5_pkg::rnd_ctrl_t ctrl;

	logic [1:0]   mode_q;
	logic [63:0]  bit_count_q, len_q;
	logic [5:0]   fill_q;
	logic [31:0]  hold_q;       // word being assembled
	logic [6:0]   rnd_q;        // 0: init/read, 1..64 rounds, 65 fold
	logic         last_pend_q;  // finish after the current compression
	logic [1:0]   ret_q;        // where to go after compression
	logic [3:0]   pad_q;        // length byte counter
	logic [3:0]   out_q;

	// byte insertion
	logic        put;
	logic [7:0]  put_byte;
	logic [31:0] merged;
	logic        mem_we;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;
	logic [127:0] chain;
	logic        final_round;

	localparam logic [1:0] RET_IDLE = 2'd0;
	localparam logic [1:0] RET_PAD  = 2'd1;
	localparam logic [1:0] RET_LEN  = 2'd2;

	logic accept;
	assign accept = start && !busy;

	always_comb begin
		case (fill_q[1:0])
			2'd0: merged = {24'h0, put_byte};
			2'd1: merged = {hold_q[31:16], put_byte, hold_q[7:0]};
			2'd2: merged = {hold_q[31:24], put_byte, hold_q[15:0]};
			default: merged = {put_byte, hold_q[23:0]};
		endcase
	end

	assign mem_we = put && (fill_q[1:0] == 2'd3);

	// Round index of the read issued this cycle; data used in the next cycle.
	logic [5:0] rd_idx;
	assign rd_idx  = rnd_q[5:0];
	assign rd_addr = md5_pkg::round_g(rd_idx);
	assign final_round = (rnd_q == 7'd65);

	md5_block_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (fill_q[5:2]),
		.wr_data (merged),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	md5_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.word   (rd_data),
		.chain  (chain)
	);

	// Output byte selection
	logic [3:0] dsel;
	logic [7:0] db0, db1, ch;
	logic [8:0] pair;
	logic [7:0] rem;
	logic [7:0] out_sel;

	function automatic logic [7:0] dig(input logic [127:0] c, input logic [3:0] k);
		return c[{k, 3'b000} +: 8];
	endfunction

	always_comb begin
		dsel = (mode_q == md5_pkg::MODE_MIDDLE) ? (out_q + 4'd4) : out_q;
		db0  = dig(chain, {out_q[2:0], 1'b0});
		db1  = dig(chain, {out_q[2:0], 1'b1});
		pair = {1'b0, db0} + {1'b0, db1};
		// pair < 511: reduce by up to eight subtractions of 62
		if (pair >= 9'd496)      rem = 8'(pair - 9'd496);
		else if (pair >= 9'd434) rem = 8'(pair - 9'd434);
		else if (pair >= 9'd372) rem = 8'(pair - 9'd372);
		else if (pair >= 9'd310) rem = 8'(pair - 9'd310);
		else if (pair >= 9'd248) rem = 8'(pair - 9'd248);
		else if (pair >= 9'd186) rem = 8'(pair - 9'd186);
		else if (pair >= 9'd124) rem = 8'(pair - 9'd124);
		else if (pair >= 9'd62)  rem = 8'(pair - 9'd62);
		else                     rem = pair[7:0];
		if (rem <= 8'd9)       ch = rem + 8'd48;
		else if (rem <= 8'd35) ch = rem + 8'd55;
		else                   ch = rem + 8'd61;
		out_sel = (mode_q == md5_pkg::MODE_BASE62) ? ch : dig(chain, dsel);
	end

	logic [3:0] out_end;
	assign out_end = (mode_q == md5_pkg::MODE_MIDDLE || mode_q == md5_pkg::MODE_BASE62)
		? 4'd7 : 4'd15;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				if (accept) begin
					if (!no_data && fill_q == 6'd63) state_d = md5_pkg::ST_ROUND;
					else if (is_last)                state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_ROUND: begin
				if (final_round) begin
					case (ret_q)
						RET_PAD: state_d = md5_pkg::ST_PAD;
						RET_LEN: state_d = last_pend_q ? md5_pkg::ST_OUT : md5_pkg::ST_LEN;
						default: state_d = last_pend_q ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
					endcase
				end
			end
			md5_pkg::ST_PAD: begin
				if (fill_q == 6'd63)      state_d = md5_pkg::ST_ROUND;
				else if (fill_q == 6'd55) state_d = md5_pkg::ST_LEN;
			end
			md5_pkg::ST_LEN: begin
				if (pad_q == 4'd7) state_d = md5_pkg::ST_ROUND;
			end
			md5_pkg::ST_OUT: begin
				if (out_q == out_end) state_d = md5_pkg::ST_IDLE;
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		put = 1'b0;
		put_byte = msg_byte;
		busy = 1'b1;
		out_valid = 1'b0;
		ctrl = '0;
		ctrl.idx = rnd_q[5:0] - 6'd1;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				busy = 1'b0;
				put = accept && !no_data;
			end
			md5_pkg::ST_ROUND: begin
				ctrl.init = (rnd_q == 7'd0);
				ctrl.run  = (rnd_q != 7'd0) && !final_round;
				ctrl.fold = final_round;
			end
			md5_pkg::ST_PAD: begin
				put = 1'b1;
				put_byte = (pad_q == 4'd0) ? md5_pkg::PAD_BYTE : 8'h00;
			end
			md5_pkg::ST_LEN: begin
				put = 1'b1;
				put_byte = len_q[{pad_q[2:0], 3'b000} +: 8];
			end
			md5_pkg::ST_OUT: begin
				out_valid = 1'b1;
				ctrl.reset_chain = (out_q == out_end);
			end
			default: busy = 1'b1;
		endcase
	end

	assign out_byte = out_sel;
	assign out_last = out_valid && (out_q == out_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md5_pkg::ST_IDLE;
			mode_q      <= md5_pkg::MODE_FULL;
			bit_count_q <= '0;
			fill_q      <= '0;
			rnd_q       <= '0;
			last_pend_q <= 1'b0;
			ret_q       <= RET_IDLE;
			pad_q       <= '0;
			out_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) mode_q <= cfg_data;
			if (put) fill_q <= fill_q + 6'd1;
			if (accept && !no_data) bit_count_q <= bit_count_q + 64'd8;
			if (accept && is_last) last_pend_q <= 1'b1;
			if (state_q == md5_pkg::ST_ROUND) rnd_q <= final_round ? 7'd0 : rnd_q + 7'd1;
			// remember where the message stood when a compression started
			if (put && fill_q == 6'd63) begin
				case (state_q)
					md5_pkg::ST_PAD: ret_q <= RET_PAD;
					md5_pkg::ST_LEN: ret_q <= RET_LEN;
					default: ret_q <= RET_IDLE;
				endcase
			end
			if (state_q == md5_pkg::ST_PAD) begin
				if (state_d == md5_pkg::ST_LEN) pad_q <= 4'd0;
				else if (pad_q == 4'd0)         pad_q <= 4'd1;
			end else if (state_q == md5_pkg::ST_LEN) begin
				pad_q <= pad_q + 4'd1;
			end
			if (state_q == md5_pkg::ST_OUT) begin
				if (out_q == out_end) begin
					out_q       <= '0;
					bit_count_q <= '0;
					fill_q      <= '0;
					last_pend_q <= 1'b0;
					pad_q       <= '0;
				end else begin
					out_q <= out_q + 4'd1;
				end
			end
		end
	end

	// Length latched as the message ends; holding word for byte merge.
	always_ff @(posedge clk) begin
		if (accept && is_last) len_q <= no_data ? bit_count_q : bit_count_q + 64'd8;
		if (put) hold_q <= merged;
	end

endmodule

// ----- test/md5_message_digest_chk.sv -----
`timescale 1ns / 1ps
// Checker: predicts MD5 digest output per message and compares each result transfer.
module md5_message_digest_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	input  logic       start,
	input  logic       busy,
	input  logic [7:0] msg_byte,
	input  logic       is_last,
	input  logic       no_data,
	input  logic       out_valid,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} digest_out_t;

	logic [31:0] chain [4];
	logic [31:0] blk [16];
	logic [63:0] nbits;
	logic [5:0]  fill;
	logic [1:0]  mode;
	digest_out_t digest_q[$];

	function automatic logic [31:0] rol(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// constant: floor(|sin(i+1)| * 2^32)
	function automatic logic [31:0] sine_k(input int i);
		real v;
		v = $sin(i + 1.0);
		if (v < 0.0) v = -v;
		return 32'(longint'(v * 4294967296.0 - 0.5));
	endfunction

	// one 64-round compression, written out from the standard algorithm
	task automatic compress_block();
		logic [31:0] a, b, c, d, f, t;
		int g, r;
		int sh [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			r = i / 16;
			case (r)
				0: begin f = (b & c) | (~b & d); g = i; end
				1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			endcase
			t = a + f + blk[g] + sine_k(i);
			t = rol(t, sh[r * 4 + i % 4]);
			a = d; d = c; c = b; b = b + t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endtask

	task automatic absorb(input logic [7:0] v);
		if (fill[1:0] == 2'd0)
			blk[fill[5:2]] = {24'd0, v};
		else
			blk[fill[5:2]][fill[1:0]*8 +: 8] = v;
		fill++;
		if (fill == 6'd0)
			compress_block();
	endtask

	task automatic chain_reset();
		chain[0] = md5_pkg::INIT_A; chain[1] = md5_pkg::INIT_B;
		chain[2] = md5_pkg::INIT_C; chain[3] = md5_pkg::INIT_D;
		nbits = '0;
		fill = '0;
	endtask

	function automatic logic [7:0] dbyte(input int k);
		return chain[k / 4][(k % 4) * 8 +: 8];
	endfunction

	task automatic predict_item(input logic [7:0] b, input logic fin, input logic none);
		logic [63:0] len;
		int v, n;
		logic [7:0] ch;
		if (!none) begin
			absorb(b);
			nbits += 64'd8;
		end
		if (fin) begin
			len = nbits;
			absorb(md5_pkg::PAD_BYTE);
			while (fill != 6'd56)
				absorb(8'h00);
			for (int i = 0; i < 8; i++)
				absorb(len[i*8 +: 8]);
			n = (mode == md5_pkg::MODE_BASE62 || mode == md5_pkg::MODE_MIDDLE) ? 8 : 16;
			for (int i = 0; i < n; i++) begin
				if (mode == md5_pkg::MODE_BASE62) begin
					v = (dbyte(2 * i) + dbyte(2 * i + 1)) % 62;
					if (v <= 9) ch = 8'(v + 48);
					else if (v <= 35) ch = 8'(v + 55);
					else ch = 8'(v + 61);
				end else if (mode == md5_pkg::MODE_MIDDLE)
					ch = dbyte(4 + i);
				else
					ch = dbyte(i);
				digest_q.push_back('{data: ch, last: (i == n - 1)});
			end
			chain_reset();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_out_t e;
		if (!arst_n) begin
			chain_reset();
			mode = md5_pkg::MODE_FULL;
			digest_q.delete();
			errors = 0;
		end else begin
			if (out_valid) begin
				if (digest_q.size() == 0) begin
					$error("unexpected result transfer out_byte=%h", out_byte);
					errors++;
				end else begin
					e = digest_q.pop_front();
					if (out_byte !== e.data) begin
						$error("out_byte expected %h actual %h", e.data, out_byte);
						errors++;
					end
					if (out_last !== e.last) begin
						$error("out_last expected %b actual %b", e.last, out_last);
						errors++;
					end
				end
			end
			if (cfg_we)
				mode = cfg_data;
			if (start && !busy)
				predict_item(msg_byte, is_last, no_data);
		end
		pending = digest_q.size();
	end

endmodule

// ----- test/md5_message_digest_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: stimulus, configuration phases and the verdict for the MD5 engine.
module md5_message_digest_tb;

	localparam int IDLE_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_data;
	logic       start;
	logic       busy;
	logic [7:0] msg_byte;
	logic       is_last;
	logic       no_data;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       out_last;
	int         errors;
	int         pending;
	int         quiet_cycles;
	bit         no_gaps;

	md5_message_digest u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.start(start), .busy(busy), .msg_byte(msg_byte), .is_last(is_last),
		.no_data(no_data), .out_valid(out_valid), .out_byte(out_byte),
		.out_last(out_last)
	);

	md5_message_digest_chk u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.start(start), .busy(busy), .msg_byte(msg_byte), .is_last(is_last),
		.no_data(no_data), .out_valid(out_valid), .out_byte(out_byte),
		.out_last(out_last), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: counts cycles with no transfer on either side and fails the test at IDLE_LIMIT.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || out_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Idle gap before an item: mostly short, now and then long.
	task automatic idle_gap();
		int n;
		if (no_gaps)
			return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
		if (n != 0)
			start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// One item transfer: start held until sampled with busy low; start is
	// dropped by the next gap or configuration write.
	task automatic send_item(input logic [7:0] b, input logic fin, input logic none);
		idle_gap();
		start    <= 1'b1;
		msg_byte <= b;
		is_last  <= fin;
		no_data  <= none;
		do @(posedge clk); while (busy);
	endtask

	// Wait until the last result has gone and the engine is idle.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		start <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Random-content message; the long lengths reach block edges (56, 63, 64).
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b1);	// idle item between bytes
			send_item(8'($urandom), (i == len - 1), 1'b0);
		end
	endtask

	int lens [3] = '{56, 63, 64};

	initial begin
		arst_n = 1'b0; cfg_we = 1'b0; cfg_data = '0; start = 1'b0;
		msg_byte = '0; is_last = 1'b0; no_data = 1'b0; no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message at reset mode, extreme bytes, short messages.
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);	// idle item, no result
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b1);	// byte ignored on an empty finish
		set_mode(md5_pkg::MODE_MIDDLE);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		set_mode(md5_pkg::MODE_BASE62);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		set_mode(2'd3);	// treated as full digest
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);

		// Random phases in randomly chosen modes (0 to 3), the first one without gaps.
		for (int p = 0; p < 8; p++) begin
			set_mode(2'($urandom_range(0, 3)));
			no_gaps = (p == 0);
			send_message(p < 3 ? lens[p] : $urandom_range(1, 4));
		end
		no_gaps = 1'b0;
		start <= 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
